// ----- src/sprite_quad_vertex_setup_defines.svh -----
// Assertion helpers used by the top-level design file.
`ifndef SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SVS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/svs_pkg.sv -----
package svs_pkg;

  localparam int CsW   = 18;
  localparam int ZW    = 33;
  localparam int HW    = 31;
  localparam int MulW  = CsW + HW;
  localparam int AccW  = 52;
  localparam int NumW  = 29;
  localparam int DenW  = 14;
  localparam int CordicSteps = 16;

  localparam logic signed [CsW-1:0] CordicStart = 18'sd19898;
  localparam logic [1:0] CfgTexWidth  = 2'd0;
  localparam logic [1:0] CfgTexHeight = 2'd1;
  localparam logic [1:0] LastCorner   = 2'd3;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [15:0]        angle;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [12:0]        src_w;
    logic [12:0]        src_h;
    logic [31:0]        color_rgba;
    logic signed [15:0] flip_pad_x;
    logic signed [15:0] flip_pad_y;
  } svs_in_t;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        color_out;
    logic [15:0]        vertex_index;
    logic [1:0]         corner;
    logic               last_corner;
  } svs_out_t;

  typedef struct packed {
    logic signed [CsW-1:0] c;
    logic signed [CsW-1:0] s;
  } svs_cs_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MHX, ST_MHY, ST_HY, ST_BASE, ST_DSTART, ST_DWAIT, ST_CWAIT,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_SUM, ST_OUT
  } svs_state_e;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10679838;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      4'd15:   r = 32'd20861;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [15:0] r;
    if (v > 33'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -33'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] satu16(input logic [NumW-1:0] q);
    logic [15:0] r;
    if (q > NumW'(65535)) begin
      r = 16'hffff;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

// ----- src/sprite_quad_vertex_setup.sv -----
// Sprite quad vertex setup: one request in, four corner words out.
// Input is stalled while busy: no new sprite is accepted until the last corner is loaded.
// Each sprite runs four 29-step divisions on the shared divider, then the states P0, P1,
// P2, P3, SUM and OUT per corner around the shared multiplier; an output stall holds the
// sequencer in ST_OUT while an output word is still pending.
// Reset clears the sequencer, the vertex counter and sets both texture sizes to 1.
`include "sprite_quad_vertex_setup_defines.svh"

module sprite_quad_vertex_setup #(
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  svs_pkg::svs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output svs_pkg::svs_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [12:0]       cfg_data_i
);
  import svs_pkg::*;

  svs_state_e state_q, state_d;

  logic [12:0] tex_w_q, tex_h_q;
  logic [15:0] cnt_q;
  logic        accept;

  logic signed [15:0] px_q, py_q, scx_q, scy_q;
  logic [11:0]        sx_q, sy_q;
  logic [12:0]        sw_q, sh_q;
  logic [31:0]        color_q;
  logic signed [18:0] fpx_q, fpy_q;
  logic               empty, fp_zero;

  logic signed [CsW-1:0]  mul_a;
  logic signed [HW-1:0]   mul_b;
  logic signed [MulW-1:0] prod_q;
  logic signed [HW-1:0]   hx_q, hy_q, dx, dy;
  logic signed [AccW-1:0] basex_q, basey_q, accx_q, accy_q, prod_ext;
  logic signed [AccW-1:0] vx_full, vy_full;
  logic signed [31:0]     vx_sh, vy_sh;
  logic signed [32:0]     vx_pad, vy_pad;

  logic [1:0]  k_q, dsel_q;
  logic [15:0] u0_q, u1_q, v0_q, v1_q;
  logic [13:0] edge_val;
  logic [12:0] dsize, dsize_raw;
  logic [NumW-1:0] num, quo;
  logic [DenW-1:0] den;
  logic            div_start, div_done, cordic_done;
  svs_cs_t         cs;

  svs_out_t out_q;
  logic     out_valid_q, slot_free, out_load;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= 13'd1;
      tex_h_q <= 13'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTexWidth:  tex_w_q <= cfg_data_i;
        CfgTexHeight: tex_h_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign empty   = (in_data_i.src_x == '0) && (in_data_i.src_y == '0) &&
                   (in_data_i.src_w == '0) && (in_data_i.src_h == '0);
  assign fp_zero = (in_data_i.flip_pad_x == '0) && (in_data_i.flip_pad_y == '0);

  svs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .angle_i (in_data_i.angle),
    .done_o  (cordic_done),
    .cs_o    (cs)
  );

  assign dsize_raw = dsel_q[1] ? tex_h_q : tex_w_q;
  assign dsize     = (dsize_raw == '0) ? 13'd1 : dsize_raw;
  always_comb begin
    case (dsel_q)
      2'd0:    edge_val = 14'(sx_q);
      2'd1:    edge_val = 14'(sx_q) + 14'(sw_q);
      2'd2:    edge_val = 14'(sy_q);
      default: edge_val = 14'(sy_q) + 14'(sh_q);
    endcase
  end
  assign num = {edge_val, 15'b0} + NumW'(dsize);
  assign den = {dsize, 1'b0};

  svs_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_MHX;
      ST_MHX:    state_d = ST_MHY;
      ST_MHY:    state_d = ST_HY;
      ST_HY:     state_d = ST_BASE;
      ST_BASE:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) state_d = (dsel_q == 2'd3) ? ST_CWAIT : ST_DSTART;
      end
      ST_CWAIT:  if (cordic_done) state_d = ST_P0;
      ST_P0:     state_d = ST_P1;
      ST_P1:     state_d = ST_P2;
      ST_P2:     state_d = ST_P3;
      ST_P3:     state_d = ST_SUM;
      ST_SUM:    state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) state_d = (k_q == LastCorner) ? ST_IDLE : ST_P0;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  assign dx = k_q[0] ? hx_q : -hx_q;
  assign dy = k_q[1] ? hy_q : -hy_q;

  always_comb begin
    mul_a     = cs.c;
    mul_b     = dx;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_MHX: begin
        mul_a = CsW'(scx_q);
        mul_b = HW'(sw_q);
      end
      ST_MHY: begin
        mul_a = CsW'(scy_q);
        mul_b = HW'(sh_q);
      end
      ST_DSTART: div_start = 1'b1;
      ST_P1: begin
        mul_a = cs.s;
        mul_b = dy;
      end
      ST_P2: begin
        mul_a = cs.s;
        mul_b = dx;
      end
      ST_P3: begin
        mul_a = cs.c;
        mul_b = dy;
      end
      ST_OUT:  out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      dsel_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + 16'd1;
        k_q         <= k_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        k_q    <= '0;
        dsel_q <= '0;
      end else if (state_q == ST_DWAIT && div_done) begin
        dsel_q <= dsel_q + 2'd1;
      end
    end
  end

  assign prod_ext = AccW'(prod_q);
  assign vx_full  = basex_q + accx_q;
  assign vy_full  = basey_q + accy_q;
  assign vx_sh    = vx_full[AccW-1:20];
  assign vy_sh    = vy_full[AccW-1:20];
  assign vx_pad   = 33'(vx_sh) + (scx_q[15] ? 33'(fpx_q) : 33'sd0);
  assign vy_pad   = 33'(vy_sh) + (scy_q[15] ? 33'(fpy_q) : 33'sd0);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= in_data_i.pos_x;
      py_q    <= in_data_i.pos_y;
      scx_q   <= in_data_i.scale_x;
      scy_q   <= in_data_i.scale_y;
      sx_q    <= in_data_i.src_x;
      sy_q    <= in_data_i.src_y;
      sw_q    <= empty ? tex_w_q : in_data_i.src_w;
      sh_q    <= empty ? tex_h_q : in_data_i.src_h;
      color_q <= in_data_i.color_rgba;
      fpx_q   <= fp_zero ? signed'({2'b0, tex_w_q, 4'b0}) : 19'(in_data_i.flip_pad_x);
      fpy_q   <= fp_zero ? signed'({2'b0, tex_h_q, 4'b0}) : 19'(in_data_i.flip_pad_y);
    end
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_MHY:  hx_q <= prod_q[HW-1:0];
      ST_HY:   hy_q <= prod_q[HW-1:0];
      ST_BASE: begin
        basex_q <= (AccW'(px_q) <<< 20) + (AccW'(hx_q) <<< 15) + AccW'(524288);
        basey_q <= (AccW'(py_q) <<< 20) + (AccW'(hy_q) <<< 15) + AccW'(524288);
      end
      ST_DWAIT: begin
        if (div_done) begin
          case (dsel_q)
            2'd0:    u0_q <= satu16(quo);
            2'd1:    u1_q <= satu16(quo);
            2'd2:    v0_q <= satu16(quo);
            default: v1_q <= satu16(quo);
          endcase
        end
      end
      ST_P1:   accx_q <= prod_ext;
      ST_P2:   accx_q <= accx_q + prod_ext;
      ST_P3:   accy_q <= -prod_ext;
      ST_SUM:  accy_q <= accy_q + prod_ext;
      default: ;
    endcase
    if (out_load) begin
      out_q.vertex_x     <= sat16(vx_pad);
      out_q.vertex_y     <= sat16(vy_pad);
      out_q.tex_u        <= k_q[0] ? u1_q : u0_q;
      out_q.tex_v        <= k_q[1] ? v1_q : v0_q;
      out_q.color_out    <= color_q;
      out_q.vertex_index <= cnt_q;
      out_q.corner       <= k_q;
      out_q.last_corner  <= (k_q == LastCorner);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SVS_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE)
  `SVS_ASSERT_NEXT(a_count_step, out_load, cnt_q == $past(cnt_q) + 16'd1)
  `SVS_ASSERT_IMPL(a_last_corner, out_valid_q, out_q.last_corner == (out_q.corner == LastCorner))
  `SVS_ASSERT_IMPL(a_load_slot, out_load, state_q == ST_OUT && slot_free)

endmodule

// ----- src/svs_cordic.sv -----
module svs_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [15:0]     angle_i,
  output logic            done_o,
  output svs_pkg::svs_cs_t cs_o
);
  import svs_pkg::*;

  localparam logic [31:0] AngMask = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  logic [31:0]           a32, turn, ar;
  logic                  neg;
  logic signed [CsW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0]  z_q, at;
  logic [3:0]            i_q;
  logic                  run_q, done_q, neg_q;

  assign a32  = ({16'b0, angle_i} & AngMask) << (32 - ANGLE_BITS);
  assign turn = a32 + 32'h4000_0000;
  assign neg  = turn[31];
  assign ar   = neg ? a32 + 32'h8000_0000 : a32;
  assign xs   = x_q >>> i_q;
  assign ys   = y_q >>> i_q;
  assign at   = ZW'(atan_turn(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (run_q) begin
      i_q <= i_q + 4'd1;
      if (i_q == 4'(CordicSteps - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CordicStart;
      y_q   <= '0;
      z_q   <= ZW'(signed'(ar));
      neg_q <= neg;
    end else if (run_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cs_o.c = neg_q ? -x_q : x_q;
  assign cs_o.s = neg_q ? -y_q : y_q;

endmodule

// ----- src/svs_divider.sv -----
module svs_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [svs_pkg::NumW-1:0] num_i,
  input  logic [svs_pkg::DenW-1:0] den_i,
  output logic                     done_o,
  output logic [svs_pkg::NumW-1:0] quo_o
);
  import svs_pkg::*;

  localparam int CntW = $clog2(NumW);

  logic [NumW-1:0] num_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [DenW:0]   trial;
  logic            fits;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;

  assign trial = {rem_q, num_q[NumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NumW - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      num_q <= {num_q[NumW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule
